>>> rtl/polyline_ribbon_expander_macros.svh
// ----------------------------------------------------------------------------
// polyline ribbon expander assertion macros
// shared concurrent check forms, clocked on clock and quiet during reset
// ----------------------------------------------------------------------------
`ifndef POLYLINE_RIBBON_EXPANDER_MACROS_SVH
`define POLYLINE_RIBBON_EXPANDER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PRX_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("polyline ribbon expander: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PRX_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("polyline ribbon expander: next-cycle check failed");

`endif

>>> rtl/prx_pkg.sv
// ----------------------------------------------------------------------------
// prx_pkg
// types, codes and helpers shared by the polyline ribbon expander
// ----------------------------------------------------------------------------
package prx_pkg;

   localparam int PRX_MAX_POINTS = 4096;
   localparam int IDX_W          = 14;
   localparam int CSR_IDX_W      = 2;
   localparam logic [31:0] THIN_LIMIT = 32'h0001_0000;

   typedef enum logic [1:0] {
      KIND_VERTEX = 2'd0,
      KIND_INDEX  = 2'd1,
      KIND_END    = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_WIDTH  = 2'd0,
      CSR_CLOSED_LOOP = 2'd1,
      CSR_COLOR_RGBA  = 2'd2
   } csr_idx_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECIDE, ST_THIN, ST_CLOSE_CHK, ST_CTHIN, ST_SEG, ST_NORM,
      ST_SQX, ST_SQY, ST_ROOT_GO, ST_ROOT, ST_MULX, ST_DIVX_GO, ST_DIVX,
      ST_MULY, ST_DIVY_GO, ST_DIVY, ST_OFFS, ST_WEMIT, ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_ACCEPT, OP_DECIDE, OP_CLOSE_LOAD, OP_SEG, OP_NORM,
      OP_SQX, OP_SQY, OP_ROOT_GO, OP_MULX, OP_DIVX_GO, OP_MULY, OP_DIVY_GO,
      OP_OFFS, OP_EMIT, OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      RS_VFIRST, RS_VCUR, RS_IDXM1, RS_IDX, RS_ICLOSE, RS_IZERO, RS_WVERT, RS_WIDX
   } rsel_type;

   typedef struct packed {
      op_type      op;
      rsel_type    sel;
      logic [2:0]  k;
   } cmd_type;

   typedef struct packed {
      logic thin;
      logic kept;
      logic count_zero;
      logic count_one;
      logic close_ok;
      logic seg_zero;
      logic norm_done;
      logic root_busy;
      logic div_busy;
      logic can_emit;
      logic can_finish;
   } sts_type;

   typedef struct packed {
      kind_type          kind;
      logic [31:0]       pos_x;
      logic [31:0]       pos_y;
      logic [31:0]       pos_z;
      logic              tex_u;
      logic              tex_v;
      logic [31:0]       color;
      logic [IDX_W-1:0]  idx;
   } rec_type;

   // corner offsets of the two quad triangles
   function automatic logic [1:0] quad_offset(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0:    r = 2'd0;
         3'd1:    r = 2'd1;
         3'd2:    r = 2'd2;
         3'd3:    r = 2'd0;
         3'd4:    r = 2'd2;
         3'd5:    r = 2'd3;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   // clamp a 34-bit signed sum to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic [33:0] v);
      logic [31:0] r;
      if (!v[33] && (v[32:31] != 2'b00)) begin
         r = 32'h7FFF_FFFF;
      end else if (v[33] && (v[32:31] != 2'b11)) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/prx_isqrt.sv
// ----------------------------------------------------------------------------
// prx_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module prx_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [62:0] radicand,
   output logic        busy,
   output logic [31:0] root
);

   logic [62:0] v_ff, v_in;
   logic [62:0] r_ff, r_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [62:0] bit_w;
   logic [63:0] trial;

   always_comb begin
      bit_w   = 63'(1) << {cnt_ff, 1'b0};
      trial   = {1'b0, r_ff} + {1'b0, bit_w};
      v_in    = v_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         v_in    = radicand;
         r_in    = '0;
         cnt_in  = 5'd31;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, v_ff} >= trial) begin
            v_in = v_ff - trial[62:0];
            r_in = (r_ff >> 1) + bit_w;
         end else begin
            r_in = r_ff >> 1;
         end
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      v_ff <= v_in;
      r_ff <= r_in;
   end

   assign busy = busy_ff;
   assign root = r_ff[31:0];

endmodule

>>> rtl/prx_div.sv
// ----------------------------------------------------------------------------
// prx_div
// restoring divider, 64-bit dividend by 33-bit divisor, 32 quotient bits
// ----------------------------------------------------------------------------
module prx_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [32:0] den,
   output logic        busy,
   output logic [31:0] quot
);

   // quotient is known to fit 32 bits, so the upper half starts as remainder
   logic [32:0] rem_ff, rem_in;
   logic [31:0] sh_ff, sh_in;
   logic [32:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [33:0] rem2;
   logic [33:0] diff;
   logic        ge;

   always_comb begin
      rem2    = {rem_ff, sh_ff[31]};
      diff    = rem2 - {1'b0, den_ff};
      ge      = rem2 >= {1'b0, den_ff};
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = {1'b0, num[63:32]};
         sh_in   = num[31:0];
         den_in  = den;
         cnt_in  = 5'd31;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[32:0] : rem2[32:0];
         sh_in  = {sh_ff[30:0], ge};
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quot = sh_ff;

endmodule

>>> rtl/prx_ctrl.sv
// ----------------------------------------------------------------------------
// prx_ctrl
// sequencer: steps the datapath through one point and its records
// ----------------------------------------------------------------------------
module prx_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output prx_pkg::cmd_type cmd,
   input  prx_pkg::sts_type sts
);
   import prx_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] sub_ff, sub_in;
   logic       closing_ff, closing_in;

   always_comb begin
      state_in   = state_ff;
      sub_in     = sub_ff;
      closing_in = closing_ff;
      cmd.op     = OP_NONE;
      cmd.sel    = RS_VCUR;
      cmd.k      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.op     = OP_DECIDE;
            closing_in = 1'b0;
            if (sts.kept && !sts.count_zero) begin
               if (sts.thin) begin
                  sub_in   = sts.count_one ? 4'd0 : 4'd1;
                  state_in = ST_THIN;
               end else begin
                  state_in = ST_SEG;
               end
            end else begin
               state_in = ST_CLOSE_CHK;
            end
         end
         ST_THIN: begin
            case (sub_ff[1:0])
               2'd0:    cmd.sel = RS_VFIRST;
               2'd1:    cmd.sel = RS_VCUR;
               2'd2:    cmd.sel = RS_IDXM1;
               default: cmd.sel = RS_IDX;
            endcase
            if (sts.can_emit) begin
               cmd.op = OP_EMIT;
               sub_in = sub_ff + 4'd1;
               if (sub_ff == 4'd3) begin
                  state_in = ST_CLOSE_CHK;
               end
            end
         end
         ST_CLOSE_CHK: begin
            closing_in = 1'b1;
            if (sts.close_ok) begin
               if (sts.thin) begin
                  sub_in   = 4'd0;
                  state_in = ST_CTHIN;
               end else begin
                  cmd.op   = OP_CLOSE_LOAD;
                  state_in = ST_SEG;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CTHIN: begin
            cmd.sel = sub_ff[0] ? RS_IZERO : RS_ICLOSE;
            if (sts.can_emit) begin
               cmd.op = OP_EMIT;
               sub_in = sub_ff + 4'd1;
               if (sub_ff == 4'd1) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SEG: begin
            cmd.op = OP_SEG;
            if (sts.seg_zero) begin
               state_in = closing_ff ? ST_FINISH : ST_CLOSE_CHK;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (sts.norm_done) begin
               state_in = ST_SQX;
            end else begin
               cmd.op = OP_NORM;
            end
         end
         ST_SQX: begin
            cmd.op   = OP_SQX;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.op   = OP_SQY;
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            cmd.op   = OP_ROOT_GO;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (!sts.root_busy) begin
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            cmd.op   = OP_MULX;
            state_in = ST_DIVX_GO;
         end
         ST_DIVX_GO: begin
            cmd.op   = OP_DIVX_GO;
            state_in = ST_DIVX;
         end
         ST_DIVX: begin
            if (!sts.div_busy) begin
               state_in = ST_MULY;
            end
         end
         ST_MULY: begin
            cmd.op   = OP_MULY;
            state_in = ST_DIVY_GO;
         end
         ST_DIVY_GO: begin
            cmd.op   = OP_DIVY_GO;
            state_in = ST_DIVY;
         end
         ST_DIVY: begin
            if (!sts.div_busy) begin
               state_in = ST_OFFS;
            end
         end
         ST_OFFS: begin
            cmd.op   = OP_OFFS;
            sub_in   = 4'd0;
            state_in = ST_WEMIT;
         end
         ST_WEMIT: begin
            if (sub_ff < 4'd4) begin
               cmd.sel = RS_WVERT;
               cmd.k   = sub_ff[2:0];
            end else begin
               cmd.sel = RS_WIDX;
               cmd.k   = 3'(sub_ff - 4'd4);
            end
            if (sts.can_emit) begin
               cmd.op = OP_EMIT;
               sub_in = sub_ff + 4'd1;
               if (sub_ff == 4'd9) begin
                  state_in = closing_ff ? ST_FINISH : ST_CLOSE_CHK;
               end
            end
         end
         ST_FINISH: begin
            if (sts.can_finish) begin
               cmd.op   = OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         sub_ff     <= '0;
         closing_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sub_ff     <= sub_in;
         closing_ff <= closing_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

>>> rtl/prx_dpath.sv
// ----------------------------------------------------------------------------
// prx_dpath
// point state, segment offset arithmetic, record build and output buffering
// ----------------------------------------------------------------------------
`include "polyline_ribbon_expander_macros.svh"

module prx_dpath #(
   parameter int MAX_POINTS = prx_pkg::PRX_MAX_POINTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  prx_pkg::cmd_type              cmd,
   output prx_pkg::sts_type              sts,
   input  logic signed [31:0]            req_point_x,
   input  logic signed [31:0]            req_point_y,
   input  logic signed [31:0]            req_point_z,
   input  logic                          req_last_point,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic signed [31:0]            rsp_pos_x,
   output logic signed [31:0]            rsp_pos_y,
   output logic signed [31:0]            rsp_pos_z,
   output logic                          rsp_tex_u,
   output logic                          rsp_tex_v,
   output logic [31:0]                   rsp_vertex_color,
   output logic [prx_pkg::IDX_W-1:0]     rsp_index_value,
   output logic                          rsp_last_result,
   input  logic                          csr_write,
   input  logic [prx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import prx_pkg::*;

   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [31:0] width_ff, width_in;
   logic        closed_ff, closed_in;
   logic [31:0] color_ff, color_in;

   logic [31:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in, cur_z_ff, cur_z_in;
   logic        cur_last_ff, cur_last_in;
   logic [31:0] first_x_ff, first_x_in, first_y_ff, first_y_in, first_z_ff, first_z_in;
   logic [31:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in, prev_z_ff, prev_z_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [IDX_W-1:0] vcount_ff, vcount_in;
   logic [IDX_W-1:0] idx_i_ff, idx_i_in;
   logic [IDX_W-1:0] base_ff, base_in;

   logic [31:0] a_x_ff, a_x_in, a_y_ff, a_y_in, a_z_ff, a_z_in;
   logic [31:0] b_x_ff, b_x_in, b_y_ff, b_y_in, b_z_ff, b_z_in;
   logic        dx_neg_ff, dx_neg_in, dy_pos_ff, dy_pos_in;
   logic [31:0] mx_ff, mx_in, my_ff, my_in;
   logic [62:0] prod_ff, prod_in;
   logic [62:0] sq_ff, sq_in;
   logic signed [32:0] nx_ff, nx_in, ny_ff, ny_in;

   rec_type hold_ff, hold_in;
   logic    hold_valid_ff, hold_valid_in;
   rec_type out_ff, out_in;
   logic    out_last_ff, out_last_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0] count14;
   logic [32:0] dx, dy;
   logic [32:0] mag_x, mag_y;
   logic [31:0] m_max;
   logic [30:0] mul_a;
   logic [31:0] mul_b;
   logic [62:0] mul_p;
   logic [62:0] radicand;
   logic [63:0] div_num;
   logic        root_busy, div_busy;
   logic [31:0] root_q, div_q;
   logic signed [32:0] q33;
   logic        out_busy;
   logic        use_b, neg_off;
   logic [31:0] pt_x, pt_y;
   logic [33:0] sum_x, sum_y;
   logic [33:0] off_x, off_y;
   rec_type     rec;
   rec_type     end_rec;

   assign count14 = IDX_W'({{IDX_W{1'b0}}, count_ff});
   assign dx      = {b_x_ff[31], b_x_ff} - {a_x_ff[31], a_x_ff};
   assign dy      = {b_y_ff[31], b_y_ff} - {a_y_ff[31], a_y_ff};
   assign mag_x   = dx[32] ? (33'd0 - dx) : dx;
   assign mag_y   = dy[32] ? (33'd0 - dy) : dy;
   assign m_max   = (mx_ff > my_ff) ? mx_ff : my_ff;
   assign out_busy = rsp_valid_ff && rsp_stall;

   // one shared multiplier for the squares and the width products
   always_comb begin
      case (cmd.op)
         OP_SQX: begin
            mul_a = mx_ff[30:0];
            mul_b = {1'b0, mx_ff[30:0]};
         end
         OP_SQY: begin
            mul_a = my_ff[30:0];
            mul_b = {1'b0, my_ff[30:0]};
         end
         OP_MULX: begin
            mul_a = my_ff[30:0];
            mul_b = width_ff;
         end
         default: begin
            mul_a = mx_ff[30:0];
            mul_b = width_ff;
         end
      endcase
   end
   assign mul_p    = 63'(mul_a) * 63'(mul_b);
   assign radicand = sq_ff + prod_ff;
   assign div_num  = {1'b0, prod_ff} + {32'd0, root_q};
   assign q33      = $signed({1'b0, div_q});

   prx_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_ROOT_GO),
      .radicand (radicand),
      .busy     (root_busy),
      .root     (root_q)
   );

   prx_div u_div (
      .clock (clock),
      .reset (reset),
      .start ((cmd.op == OP_DIVX_GO) || (cmd.op == OP_DIVY_GO)),
      .num   (div_num),
      .den   ({root_q, 1'b0}),
      .busy  (div_busy),
      .quot  (div_q)
   );

   // wide corner: a or b end, plus or minus the offset
   always_comb begin
      use_b = (cmd.k == 3'd1) || (cmd.k == 3'd2);
      neg_off = cmd.k[1];
      pt_x  = use_b ? b_x_ff : a_x_ff;
      pt_y  = use_b ? b_y_ff : a_y_ff;
      off_x = {nx_ff[32], nx_ff};
      off_y = {ny_ff[32], ny_ff};
      if (neg_off) begin
         off_x = 34'd0 - off_x;
         off_y = 34'd0 - off_y;
      end
      sum_x = {{2{pt_x[31]}}, pt_x} + off_x;
      sum_y = {{2{pt_y[31]}}, pt_y} + off_y;
   end

   always_comb begin
      end_rec.kind  = KIND_END;
      end_rec.pos_x = '0;
      end_rec.pos_y = '0;
      end_rec.pos_z = '0;
      end_rec.tex_u = 1'b0;
      end_rec.tex_v = 1'b0;
      end_rec.color = '0;
      end_rec.idx   = '0;
      rec       = end_rec;
      rec.kind  = KIND_INDEX;
      case (cmd.sel)
         RS_VFIRST: begin
            rec.kind  = KIND_VERTEX;
            rec.pos_x = first_x_ff;
            rec.pos_y = first_y_ff;
            rec.pos_z = first_z_ff;
            rec.color = color_ff;
         end
         RS_VCUR: begin
            rec.kind  = KIND_VERTEX;
            rec.pos_x = cur_x_ff;
            rec.pos_y = cur_y_ff;
            rec.pos_z = cur_z_ff;
            rec.color = color_ff;
         end
         RS_IDXM1:  rec.idx = idx_i_ff - IDX_W'(1);
         RS_IDX:    rec.idx = idx_i_ff;
         RS_ICLOSE: rec.idx = count14 - IDX_W'(1);
         RS_IZERO:  rec.idx = '0;
         RS_WVERT: begin
            rec.kind  = KIND_VERTEX;
            rec.pos_x = sat32(sum_x);
            rec.pos_y = sat32(sum_y);
            rec.pos_z = use_b ? b_z_ff : a_z_ff;
            rec.tex_u = use_b;
            rec.tex_v = neg_off;
            rec.color = color_ff;
         end
         RS_WIDX:   rec.idx = base_ff + IDX_W'(quad_offset(cmd.k));
         default:   rec.idx = '0;
      endcase
   end

   always_comb begin
      width_in = width_ff;
      closed_in = closed_ff;
      color_in = color_ff;
      cur_x_in = cur_x_ff; cur_y_in = cur_y_ff; cur_z_in = cur_z_ff;
      cur_last_in = cur_last_ff;
      first_x_in = first_x_ff; first_y_in = first_y_ff; first_z_in = first_z_ff;
      prev_x_in = prev_x_ff; prev_y_in = prev_y_ff; prev_z_in = prev_z_ff;
      count_in = count_ff;
      vcount_in = vcount_ff;
      idx_i_in = idx_i_ff;
      base_in = base_ff;
      a_x_in = a_x_ff; a_y_in = a_y_ff; a_z_in = a_z_ff;
      b_x_in = b_x_ff; b_y_in = b_y_ff; b_z_in = b_z_ff;
      dx_neg_in = dx_neg_ff;
      dy_pos_in = dy_pos_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      prod_in = prod_ff;
      sq_in = sq_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      hold_in = hold_ff;
      hold_valid_in = hold_valid_ff;
      out_in = out_ff;
      out_last_in = out_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_write) begin
         case (csr_index)
            CSR_LINE_WIDTH:  width_in  = csr_data;
            CSR_CLOSED_LOOP: closed_in = csr_data[0];
            CSR_COLOR_RGBA:  color_in  = csr_data;
            default:         width_in  = width_ff;
         endcase
      end

      case (cmd.op)
         OP_ACCEPT: begin
            cur_x_in    = req_point_x;
            cur_y_in    = req_point_y;
            cur_z_in    = req_point_z;
            cur_last_in = req_last_point;
         end
         OP_DECIDE: begin
            if (sts.kept) begin
               if (sts.count_zero) begin
                  first_x_in = cur_x_ff;
                  first_y_in = cur_y_ff;
                  first_z_in = cur_z_ff;
               end
               a_x_in = prev_x_ff; a_y_in = prev_y_ff; a_z_in = prev_z_ff;
               b_x_in = cur_x_ff;  b_y_in = cur_y_ff;  b_z_in = cur_z_ff;
               prev_x_in = cur_x_ff; prev_y_in = cur_y_ff; prev_z_in = cur_z_ff;
               idx_i_in = count14;
               count_in = count_ff + CW'(1);
            end
         end
         OP_CLOSE_LOAD: begin
            a_x_in = prev_x_ff;  a_y_in = prev_y_ff;  a_z_in = prev_z_ff;
            b_x_in = first_x_ff; b_y_in = first_y_ff; b_z_in = first_z_ff;
         end
         OP_SEG: begin
            mx_in     = mag_x[31:0];
            my_in     = mag_y[31:0];
            dx_neg_in = dx[32];
            dy_pos_in = !dy[32] && (dy != 33'd0);
            base_in   = vcount_ff;
         end
         OP_NORM: begin
            if (m_max[31]) begin
               mx_in = mx_ff >> 1;
               my_in = my_ff >> 1;
            end else begin
               mx_in = mx_ff << 1;
               my_in = my_ff << 1;
            end
         end
         OP_SQX: prod_in = mul_p;
         OP_SQY: begin
            sq_in   = prod_ff;
            prod_in = mul_p;
         end
         OP_MULX: prod_in = mul_p;
         OP_MULY: begin
            prod_in = mul_p;
            nx_in   = dy_pos_ff ? -q33 : q33;
         end
         OP_OFFS: ny_in = dx_neg_ff ? -q33 : q33;
         OP_EMIT: begin
            if (hold_valid_ff) begin
               out_in       = hold_ff;
               out_last_in  = 1'b0;
               rsp_valid_in = 1'b1;
            end
            hold_in       = rec;
            hold_valid_in = 1'b1;
            if (rec.kind == KIND_VERTEX) begin
               vcount_in = vcount_ff + IDX_W'(1);
            end
         end
         OP_FINISH: begin
            if (cur_last_ff) begin
               out_in       = hold_valid_ff ? hold_ff : end_rec;
               out_last_in  = 1'b1;
               rsp_valid_in = 1'b1;
               first_x_in = '0; first_y_in = '0; first_z_in = '0;
               prev_x_in  = '0; prev_y_in  = '0; prev_z_in  = '0;
               count_in   = '0;
               vcount_in  = '0;
            end else if (hold_valid_ff) begin
               out_in       = hold_ff;
               out_last_in  = 1'b0;
               rsp_valid_in = 1'b1;
            end
            hold_valid_in = 1'b0;
         end
         default: begin
            hold_valid_in = hold_valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= THIN_LIMIT;
         closed_ff     <= 1'b0;
         color_ff      <= 32'hFFFF_FFFF;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         first_z_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_z_ff     <= '0;
         count_ff      <= '0;
         vcount_ff     <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         closed_ff     <= closed_in;
         color_ff      <= color_in;
         first_x_ff    <= first_x_in;
         first_y_ff    <= first_y_in;
         first_z_ff    <= first_z_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         prev_z_ff     <= prev_z_in;
         count_ff      <= count_in;
         vcount_ff     <= vcount_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cur_z_ff    <= cur_z_in;
      cur_last_ff <= cur_last_in;
      idx_i_ff    <= idx_i_in;
      base_ff     <= base_in;
      a_x_ff      <= a_x_in;
      a_y_ff      <= a_y_in;
      a_z_ff      <= a_z_in;
      b_x_ff      <= b_x_in;
      b_y_ff      <= b_y_in;
      b_z_ff      <= b_z_in;
      dx_neg_ff   <= dx_neg_in;
      dy_pos_ff   <= dy_pos_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      prod_ff     <= prod_in;
      sq_ff       <= sq_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      sts.thin       = width_ff <= THIN_LIMIT;
      sts.kept       = count_ff < CW'(MAX_POINTS);
      sts.count_zero = count_ff == '0;
      sts.count_one  = count_ff == CW'(1);
      sts.close_ok   = cur_last_ff && closed_ff && (count_ff >= CW'(2));
      sts.seg_zero   = (dx == 33'd0) && (dy == 33'd0);
      sts.norm_done  = !m_max[31] && m_max[30];
      sts.root_busy  = root_busy;
      sts.div_busy   = div_busy;
      sts.can_emit   = !hold_valid_ff || !out_busy;
      sts.can_finish = cur_last_ff ? !out_busy : (!hold_valid_ff || !out_busy);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_pos_x        = out_ff.pos_x;
   assign rsp_pos_y        = out_ff.pos_y;
   assign rsp_pos_z        = out_ff.pos_z;
   assign rsp_tex_u        = out_ff.tex_u;
   assign rsp_tex_v        = out_ff.tex_v;
   assign rsp_vertex_color = out_ff.color;
   assign rsp_index_value  = out_ff.idx;
   assign rsp_last_result  = out_last_ff;

   `PRX_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CW'(MAX_POINTS))
   `PRX_ASSERT_IMPL(a_emit_room, cmd.op == OP_EMIT, !hold_valid_ff || !out_busy)
   `PRX_ASSERT_IMPL(a_div_idle, (cmd.op == OP_DIVX_GO) || (cmd.op == OP_DIVY_GO), !div_busy)
   `PRX_ASSERT_NEXT(a_end_clears, (cmd.op == OP_FINISH) && cur_last_ff, (count_ff == '0) && (vcount_ff == '0) && rsp_valid_ff && out_last_ff)

endmodule

>>> rtl/polyline_ribbon_expander.sv
// ----------------------------------------------------------------------------
// polyline_ribbon_expander
// a thin point's records pass from decide to emit; a wide point first runs the segment,
//   normalizer, root and two divides, and the closing segment of a loop runs it once more
// a new point is taken only after every record of the last one has gone to the output
// output stalls hold the sequencer while a record waits in the output register and the hold stage is full
// reset: registers to defaults, point state cleared at once, no clearing pass
// ----------------------------------------------------------------------------
module polyline_ribbon_expander #(
   parameter int MAX_POINTS = prx_pkg::PRX_MAX_POINTS
) (
   input  logic                          clock,
   input  logic                          reset,
   // point input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [31:0]            req_point_x,
   input  logic signed [31:0]            req_point_y,
   input  logic signed [31:0]            req_point_z,
   input  logic                          req_last_point,
   // record output channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic signed [31:0]            rsp_pos_x,
   output logic signed [31:0]            rsp_pos_y,
   output logic signed [31:0]            rsp_pos_z,
   output logic                          rsp_tex_u,
   output logic                          rsp_tex_v,
   output logic [31:0]                   rsp_vertex_color,
   output logic [prx_pkg::IDX_W-1:0]     rsp_index_value,
   output logic                          rsp_last_result,
   // register write port
   input  logic                          csr_write,
   input  logic [prx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import prx_pkg::*;

   // the sequencer takes one point per transfer and holds req_stall until
   // every record of that point sits in the output register or hold stage
   cmd_type cmd;
   sts_type sts;

   prx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: point registers, offset math, record build; one record is kept
   // back in a hold stage so the final one can carry last_result
   prx_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .req_last_point   (req_last_point),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v        (rsp_tex_v),
      .rsp_vertex_color (rsp_vertex_color),
      .rsp_index_value  (rsp_index_value),
      .rsp_last_result  (rsp_last_result),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

endmodule

>>> dv/polyline_ribbon_expander_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline ribbon expander testbench
// streams polylines in thin and wide mode, open and closed, predicts every
// vertex, index and end record and compares them as they leave the block
// ----------------------------------------------------------------------------
module polyline_ribbon_expander_tb;
   import prx_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 400;

   // one expected output record
   typedef struct {
      logic [1:0]  kind;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic        tu;
      logic        tv;
      logic [31:0] col;
      logic [13:0] idx;
      logic        lst;
   } record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_point_x = '0;
   logic [31:0] req_point_y = '0;
   logic [31:0] req_point_z = '0;
   logic        req_last_point = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic        rsp_tex_u, rsp_tex_v;
   logic [31:0] rsp_vertex_color;
   logic [IDX_W-1:0] rsp_index_value;
   logic        rsp_last_result;
   logic        csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LINE_WIDTH;
   logic [31:0] csr_data = '0;

   polyline_ribbon_expander u_top (.*);

   always #10 clock = ~clock;

   // shadow registers and point state
   logic [31:0] width_q;
   logic        loop_q;
   logic [31:0] color_q;
   logic signed [63:0] fst_x, fst_y, fst_z, prv_x, prv_y, prv_z;
   int unsigned pts_held;
   logic [13:0] vtx_cnt;

   record_type  pending_records[$];
   int          error_count = 0;
   int          records_seen = 0;
   int          points_sent = 0;
   int          idle_cycles = 0;
   bit          hold_off = 0;
   bit          rsp_quiet = 0;

   always @(posedge clock) begin
      if (req_valid && !req_stall || rsp_valid && !rsp_stall) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("%0t watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // append one expectation at the tail of the queue
   function automatic void add_expected(input record_type r);
      pending_records.insert(pending_records.size(), r);
   endfunction

   function automatic void push_vertex(input logic signed [63:0] x, y, z,
                                       input logic u, v);
      record_type r;
      r = '{KIND_VERTEX, clamp32(x), clamp32(y), clamp32(z), u, v, color_q, 14'd0, 1'b0};
      add_expected(r);
      vtx_cnt = vtx_cnt + 14'd1;
   endfunction

   function automatic void push_index(input logic [13:0] i);
      record_type r;
      r = '{KIND_INDEX, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, i, 1'b0};
      add_expected(r);
   endfunction

   function automatic void expand_quad(input logic signed [63:0] ax, ay, az, bx, by, bz);
      logic signed [63:0] dx, dy, nx, ny;
      logic [63:0] mx, my, m, len, qx, qy;
      logic [13:0] base;
      dx = bx - ax;
      dy = by - ay;
      if (dx == 0 && dy == 0) return;
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      m = mx > my ? mx : my;
      while (m < (64'd1 << 30)) begin
         mx = mx << 1; my = my << 1; m = m << 1;
      end
      while (m >= (64'd1 << 31)) begin
         mx = mx >> 1; my = my >> 1; m = m >> 1;
      end
      len = int_sqrt(mx * mx + my * my);
      qx = (my * width_q + len) / (2 * len);
      qy = (mx * width_q + len) / (2 * len);
      nx = dy > 0 ? -$signed(qx) : $signed(qx);
      ny = dx < 0 ? -$signed(qy) : $signed(qy);
      base = vtx_cnt;
      push_vertex(ax + nx, ay + ny, az, 1'b0, 1'b0);
      push_vertex(bx + nx, by + ny, bz, 1'b1, 1'b0);
      push_vertex(bx - nx, by - ny, bz, 1'b1, 1'b1);
      push_vertex(ax - nx, ay - ny, az, 1'b0, 1'b1);
      push_index(base);     push_index(base + 14'd1); push_index(base + 14'd2);
      push_index(base);     push_index(base + 14'd2); push_index(base + 14'd3);
   endfunction

   function automatic void predict_point(input logic [31:0] x, y, z, input logic lst);
      logic signed [63:0] sx, sy, sz;
      bit thin;
      int before_n;
      record_type r;
      sx = $signed(x); sy = $signed(y); sz = $signed(z);
      thin = width_q <= THIN_LIMIT;
      before_n = pending_records.size();
      if (pts_held < PRX_MAX_POINTS) begin
         if (pts_held == 0) begin
            fst_x = sx; fst_y = sy; fst_z = sz;
         end else if (thin) begin
            if (pts_held == 1) push_vertex(fst_x, fst_y, fst_z, 1'b0, 1'b0);
            push_vertex(sx, sy, sz, 1'b0, 1'b0);
            push_index(14'(pts_held - 1));
            push_index(14'(pts_held));
         end else begin
            expand_quad(prv_x, prv_y, prv_z, sx, sy, sz);
         end
         prv_x = sx; prv_y = sy; prv_z = sz;
         pts_held++;
      end
      if (lst) begin
         if (loop_q && pts_held >= 2) begin
            if (thin) begin
               push_index(14'(pts_held - 1));
               push_index(14'd0);
            end else begin
               expand_quad(prv_x, prv_y, prv_z, fst_x, fst_y, fst_z);
            end
         end
         if (pending_records.size() == before_n) begin
            r = '{KIND_END, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 14'd0, 1'b0};
            add_expected(r);
         end
         pending_records[pending_records.size() - 1].lst = 1'b1;
         fst_x = 0; fst_y = 0; fst_z = 0; prv_x = 0; prv_y = 0; prv_z = 0;
         pts_held = 0;
         vtx_cnt = 0;
      end
   endfunction

   // ---------------------------------------------------------------- result side
   // random stall, mostly short, now and then long, sometimes none at all
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end else if (rsp_quiet || $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
            rsp_stall <= 1'b1;
            repeat (n + 1) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // compare each record transfer with the oldest expectation
   always @(posedge clock) begin
      record_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         records_seen <= records_seen + 1;
         if (pending_records.size() == 0) begin
            $display("%0t unexpected record: kind %0d idx %0d", $time, rsp_kind,
                     rsp_index_value);
            error_count <= error_count + 1;
         end else begin
            e = pending_records.pop_front();
            if ({rsp_kind, rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_tex_u, rsp_tex_v,
                 rsp_vertex_color, rsp_index_value, rsp_last_result} !==
                {e.kind, e.px, e.py, e.pz, e.tu, e.tv, e.col, e.idx, e.lst}) begin
               $display("%0t expected kind %0d pos %h %h %h uv %b%b col %h idx %0d last %b",
                        $time, e.kind, e.px, e.py, e.pz, e.tu, e.tv, e.col, e.idx, e.lst);
               $display("%0t actual   kind %0d pos %h %h %h uv %b%b col %h idx %0d last %b",
                        $time, rsp_kind, rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_tex_u,
                        rsp_tex_v, rsp_vertex_color, rsp_index_value, rsp_last_result);
               error_count <= error_count + 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic send_point(input logic [31:0] x, y, z, input logic lst);
      req_valid      <= 1'b1;
      req_point_x    <= x;
      req_point_y    <= y;
      req_point_z    <= z;
      req_last_point <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // the transfer happened at this edge
      predict_point(x, y, z, lst);
      points_sent++;
      if (!rsp_quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                             : $urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic park_input();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every expected record, then the block's tail latency
   task automatic drain();
      park_input();
      while (pending_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type i, input logic [31:0] d);
      csr_write <= 1'b1;
      csr_index <= i;
      csr_data  <= d;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (i)
         CSR_LINE_WIDTH:  width_q = d;
         CSR_CLOSED_LOOP: loop_q  = d[0];
         default:         color_q = d;
      endcase
   endtask

   task automatic set_mode(input logic [31:0] w, input logic lp, input logic [31:0] c);
      drain();
      write_csr(CSR_LINE_WIDTH, w);
      write_csr(CSR_CLOSED_LOOP, {31'd0, lp});
      write_csr(CSR_COLOR_RGBA, c);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'(($urandom))};
         2:       return $urandom_range(0, 1) ? 32'h7FFF_0000 + $urandom_range(0, 65535)
                                               : 32'h8000_0000 + $urandom_range(0, 65535);
         default: return $signed($urandom_range(0, 400 << 16)) - (200 << 16);
      endcase
   endfunction

   function automatic logic [31:0] rand_width();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 32'h0001_0000);
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
         2:       return $urandom();
         default: return $urandom_range(32'h0001_0001, 32'h0010_0000);
      endcase
   endfunction

   // single point, empty loop, minimum widths; end markers come out
   task automatic test_silent_endings();
      set_mode(32'h0000_0000, 1'b1, 32'h0000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
      set_mode(32'h0001_0001, 1'b1, 32'hFFFF_FFFF);
      send_point(32'h0001_0000, 32'h0002_0000, 32'h0, 1'b1);
      // coincident pair in wide mode, open
      drain();
      write_csr(CSR_CLOSED_LOOP, 32'd0);
      send_point(32'h0005_0000, 32'h0005_0000, 32'h1, 1'b0);
      send_point(32'h0005_0000, 32'h0005_0000, 32'h2, 1'b1);
   endtask

   // thin mode at the threshold, open and closed
   task automatic test_thin_lines();
      set_mode(32'h0001_0000, 1'b0, 32'h1234_5678);
      send_point(32'h0, 32'h0, 32'h0, 1'b0);
      send_point(32'h0001_0000, 32'h0, 32'h8000_0000, 1'b0);
      send_point(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1);
      drain();
      write_csr(CSR_CLOSED_LOOP, 32'd1);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h5, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h6, 1'b0);
      send_point(32'h0, 32'h0, 32'h7, 1'b1);
   endtask

   // widest ribbon at extreme coordinates: positions saturate; then a narrower open ribbon
   task automatic test_wide_saturation();
      set_mode(32'hFFFF_FFFF, 1'b1, 32'hA5A5_5A5A);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b1);
      set_mode(32'h0003_0000, 1'b0, 32'h0F0F_F0F0);
      send_point(32'h0, 32'h0, 32'h0, 1'b0);
      send_point(32'h0, 32'h0000_0001, 32'h0, 1'b0);
      send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 1'b0);
      send_point(32'h0010_0000, 32'hFFF0_0000, 32'h0, 1'b1);
   endtask

   // receiver held off while thin points keep coming
   task automatic test_backpressure();
      set_mode(32'h0000_8000, 1'b0, 32'hCAFE_F00D);
      hold_off = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 20; i++)
            send_point($urandom(), $urandom(), $urandom(), i == 19);
      join
   endtask

   // bursts of polylines with random content and random mode changes
   task automatic test_random_polylines(input int n_points);
      int n, len;
      n = 0;
      while (n < n_points) begin
         if ($urandom_range(0, 3) == 0)
            set_mode(rand_width(), 1'($urandom_range(0, 1)), $urandom());
         rsp_quiet = ($urandom_range(0, 7) == 0);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 8);
         for (int i = 0; i < len; i++) begin
            // an occasional repeated point gives a coincident segment
            if (i > 0 && $urandom_range(0, 9) == 0)
               send_point(prv_x[31:0], prv_y[31:0], $urandom(), i == len - 1);
            else
               send_point(rand_coord(), rand_coord(), $urandom(), i == len - 1);
         end
         rsp_quiet = 0;
         n += len;
      end
   endtask

   initial begin
      width_q = 32'h0001_0000;
      loop_q  = 1'b0;
      color_q = 32'hFFFF_FFFF;
      fst_x = 0; fst_y = 0; fst_z = 0; prv_x = 0; prv_y = 0; prv_z = 0;
      pts_held = 0;
      vtx_cnt = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_silent_endings();
      test_thin_lines();
      test_wide_saturation();
      test_backpressure();
      test_random_polylines(215);
      drain();
      $display("covered %0d points and %0d records in thin and wide modes,", points_sent,
               records_seen);
      $display("open and closed loops, saturation, coincident segments and stalls");
      if (error_count == 0 && pending_records.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d records never arrived", error_count,
                  pending_records.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> polyline_ribbon_expander.f
+incdir+rtl
rtl/prx_pkg.sv
rtl/prx_isqrt.sv
rtl/prx_div.sv
rtl/prx_ctrl.sv
rtl/prx_dpath.sv
rtl/polyline_ribbon_expander.sv
dv/polyline_ribbon_expander_tb.sv
